[rtl/core/pgcl_pkg.sv]
// ----------------------------------------------------------------------------
// pgcl_pkg
// Shared widths, defaults and state encoding for the previous greater
// chain length block.
// ----------------------------------------------------------------------------
package pgcl_pkg;

   localparam int SAMPLE_W          = 10;
   localparam int OUT_W             = 11;
   localparam int EPOCH_BITS        = 8;
   localparam int VALUE_BITS_DEFAULT = 10;
   localparam int MAX_ITEMS_DEFAULT = 1024;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_SEARCH,
      ST_DRAIN,
      ST_LREAD,
      ST_LWAIT,
      ST_UPDATE,
      ST_EMIT
   } pgcl_state_type;

endpackage

[rtl/core/previous_greater_chain_length.sv]
// ----------------------------------------------------------------------------
// previous_greater_chain_length
// For each item, finds the latest earlier item of the sequence with a greater
// value and reports that item's position and its chain length plus one.
//
// Input channel req_*: one value and a first_of_sequence flag per item.
// Result channel rsp_*: chain length, greater position and overflow flag,
// exactly one result per item, in order.
// Between accept and the next accept, an item does one tree read per level
// for the suffix maximum, one read and one write of the length memory, then
// one tree write per level for the update, all through the single port of
// the tree memory; a large value ends the suffix walk early. No new item is
// accepted until the result has gone into the output register.
// Tree entries carry an epoch tag, so a new sequence empties the tree at once;
// only when the epoch counter wraps (every 2^8 sequences) and after reset does
// a clearing pass over all 2^(VALUE_BITS+1) entries run through the tree memory.
// During the pass after reset req_stall is high.
// The result sits in an output register: a stalled receiver holds it there
// while the next item is already accepted and worked on; that item waits
// only at its end for the register to free up.
// ----------------------------------------------------------------------------
module previous_greater_chain_length
   import pgcl_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT,
   parameter int MAX_ITEMS  = MAX_ITEMS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [SAMPLE_W-1:0] req_sample_value,
   input  logic                req_first_of_sequence,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [OUT_W-1:0]    rsp_chain_length,
   output logic [OUT_W-1:0]    rsp_greater_position,
   output logic                rsp_overflow
);

   localparam int LEAVES = 1 << VALUE_BITS;
   localparam int NODE_W = VALUE_BITS + 1;
   localparam int WALK_W = VALUE_BITS + 2;
   localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
   localparam int LA_W   = $clog2(MAX_ITEMS);
   localparam int TW     = EPOCH_BITS + CNT_W;

   // memories
   logic [TW-1:0]    tree_mem [2*LEAVES];
   logic [CNT_W-1:0] len_mem  [MAX_ITEMS];

   logic              tree_we;
   logic [NODE_W-1:0] tree_addr;
   logic [TW-1:0]     tree_wdata;
   logic [TW-1:0]     tree_rdata_ff;
   logic              len_we;
   logic [LA_W-1:0]   len_addr;
   logic [CNT_W-1:0]  len_wdata;
   logic [CNT_W-1:0]  len_rdata_ff;

   always_ff @(posedge clock) begin
      if (tree_we) begin
         tree_mem[tree_addr] <= tree_wdata;
      end
      tree_rdata_ff <= tree_mem[tree_addr];
   end

   always_ff @(posedge clock) begin
      if (len_we) begin
         len_mem[len_addr] <= len_wdata;
      end
      len_rdata_ff <= len_mem[len_addr];
   end

   // state
   pgcl_state_type    state_ff, state_in;
   logic [NODE_W-1:0] clr_addr_ff, clr_addr_in;
   logic              item_pend_ff, item_pend_in;
   logic [EPOCH_BITS-1:0] epoch_ff, epoch_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic [CNT_W-1:0]  pos_ff, pos_in;
   logic [WALK_W-1:0] l_ff, l_in;
   logic [WALK_W-1:0] r_ff, r_in;
   logic              rd_pend_ff, rd_pend_in;
   logic [CNT_W-1:0]  best_ff, best_in;
   logic [CNT_W-1:0]  len_ff, len_in;
   logic [NODE_W-1:0] node_ff, node_in;
   logic              ovf_ff, ovf_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]  rsp_len_ff, rsp_len_in;
   logic [OUT_W-1:0]  rsp_gpos_ff, rsp_gpos_in;
   logic              rsp_ovf_ff, rsp_ovf_in;

   logic                  accept;
   logic                  rsp_free;
   logic [CNT_W-1:0]      cnt_eff;
   logic                  cnt_full;
   logic [VALUE_BITS+SAMPLE_W-1:0] value_ext;
   logic [VALUE_BITS-1:0] sample_val;
   logic [EPOCH_BITS-1:0] rd_epoch;
   logic [CNT_W-1:0]      rd_pos;
   logic                  search_more;
   logic [OUT_W+CNT_W-1:0] len_ext;
   logic [OUT_W+CNT_W-1:0] gpos_ext;

   assign accept     = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign value_ext  = {{VALUE_BITS{1'b0}}, req_sample_value};
   assign sample_val = value_ext[VALUE_BITS-1:0];
   assign cnt_eff    = req_first_of_sequence ? '0 : cnt_ff;
   assign cnt_full   = (cnt_eff >= CNT_W'(MAX_ITEMS));
   assign rd_epoch   = tree_rdata_ff[TW-1 -: EPOCH_BITS];
   assign rd_pos     = tree_rdata_ff[CNT_W-1:0];
   assign search_more = (l_ff < r_ff);
   assign len_ext    = {{OUT_W{1'b0}}, (ovf_ff ? {CNT_W{1'b0}} : len_ff)};
   assign gpos_ext   = {{OUT_W{1'b0}}, (ovf_ff ? {CNT_W{1'b0}} : best_ff)};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (cnt_full) begin
                  state_in = ST_EMIT;
               end else if (req_first_of_sequence && (&epoch_ff)) begin
                  state_in = ST_CLEAR;
               end else begin
                  state_in = ST_SEARCH;
               end
            end
         end
         ST_CLEAR: begin
            if (&clr_addr_ff) begin
               state_in = item_pend_ff ? ST_SEARCH : ST_IDLE;
            end
         end
         ST_SEARCH: begin
            if (!search_more) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN:  state_in = ST_LREAD;
         ST_LREAD:  state_in = ST_LWAIT;
         ST_LWAIT:  state_in = ST_UPDATE;
         ST_UPDATE: begin
            if (node_ff == NODE_W'(1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_stall    = (state_ff != ST_IDLE);
      tree_we      = 1'b0;
      tree_addr    = l_ff[NODE_W-1:0];
      tree_wdata   = {epoch_ff, pos_ff};
      len_we       = 1'b0;
      len_addr     = pos_ff[LA_W-1:0] - LA_W'(1);
      len_wdata    = len_ff;
      clr_addr_in  = clr_addr_ff;
      item_pend_in = item_pend_ff;
      epoch_in     = epoch_ff;
      cnt_in       = cnt_ff;
      value_in     = value_ff;
      pos_in       = pos_ff;
      l_in         = l_ff;
      r_in         = r_ff;
      rd_pend_in   = 1'b0;
      best_in      = best_ff;
      len_in       = len_ff;
      node_in      = node_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_len_in   = rsp_len_ff;
      rsp_gpos_in  = rsp_gpos_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      // fold in the tree entry read last cycle; stale epochs count as empty
      if (rd_pend_ff && (rd_epoch == epoch_ff) && (rd_pos > best_ff)) begin
         best_in = rd_pos;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               item_pend_in = 1'b1;
               value_in     = sample_val;
               ovf_in       = cnt_full;
               best_in      = '0;
               cnt_in       = cnt_full ? cnt_eff : cnt_eff + CNT_W'(1);
               pos_in       = cnt_eff + CNT_W'(1);
               l_in         = {2'b01, sample_val} + WALK_W'(1);
               r_in         = {2'b10, {VALUE_BITS{1'b0}}};
               if (req_first_of_sequence) begin
                  epoch_in = epoch_ff + EPOCH_BITS'(1);
               end
            end
         end
         ST_CLEAR: begin
            tree_we     = 1'b1;
            tree_addr   = clr_addr_ff;
            tree_wdata  = '0;
            clr_addr_in = clr_addr_ff + NODE_W'(1);
         end
         ST_SEARCH: begin
            if (search_more) begin
               rd_pend_in = l_ff[0];
               l_in       = (l_ff + WALK_W'(l_ff[0])) >> 1;
               r_in       = r_ff >> 1;
            end
         end
         ST_DRAIN: begin
         end
         ST_LREAD: begin
            len_addr = best_ff[LA_W-1:0] - LA_W'(1);
         end
         ST_LWAIT: begin
            len_in    = (best_ff != '0) ? len_rdata_ff + CNT_W'(1) : CNT_W'(1);
            len_we    = 1'b1;
            len_wdata = len_in;
            node_in   = {1'b1, value_ff};
         end
         ST_UPDATE: begin
            // newest position is the largest, so every ancestor takes it
            tree_we   = 1'b1;
            tree_addr = node_ff;
            node_in   = node_ff >> 1;
         end
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_len_in   = len_ext[OUT_W-1:0];
               rsp_gpos_in  = gpos_ext[OUT_W-1:0];
               rsp_ovf_in   = ovf_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         item_pend_ff <= 1'b0;
         epoch_ff     <= '0;
         cnt_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         item_pend_ff <= item_pend_in;
         epoch_ff     <= epoch_in;
         cnt_ff       <= cnt_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff    <= value_in;
      pos_ff      <= pos_in;
      l_ff        <= l_in;
      r_ff        <= r_in;
      best_ff     <= best_in;
      len_ff      <= len_in;
      node_ff     <= node_in;
      ovf_ff      <= ovf_in;
      rsp_len_ff  <= rsp_len_in;
      rsp_gpos_ff <= rsp_gpos_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_chain_length     = rsp_len_ff;
   assign rsp_greater_position = rsp_gpos_ff;
   assign rsp_overflow         = rsp_ovf_ff;

endmodule

[tb/tb_previous_greater_chain_length.sv]
// ----------------------------------------------------------------------------
// tb_previous_greater_chain_length
// Streams value sequences through the previous greater chain length block.
// A local copy of the max-position tree predicts each result. The stimulus
// covers value extremes, equal and falling runs, sequences that run past
// capacity, and enough sequences to wrap the epoch counter. The input channel
// idles and the result channel stalls at random.
// ----------------------------------------------------------------------------
module tb_previous_greater_chain_length
   import pgcl_pkg::*;
();

   localparam int LEAVES        = 1 << VALUE_BITS_DEFAULT;
   localparam int CAPACITY      = MAX_ITEMS_DEFAULT;
   localparam int IDLE_PCT      = 12;
   localparam int HOLD_START    = 8000;
   localparam int HOLD_LEN      = 400;
   localparam int QUIET_START   = 20000;
   localparam int QUIET_END     = 26000;
   localparam int STYLE_UNIFORM = 0;
   localparam int STYLE_FALLING = 1;
   localparam int STYLE_CLUSTER = 2;
   localparam int STYLE_EXTREME = 3;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                first;
      logic                drain;
   } value_item_type;

   typedef struct packed {
      logic [OUT_W-1:0] chain_length;
      logic [OUT_W-1:0] greater_position;
      logic             overflow;
   } chain_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [SAMPLE_W-1:0] req_sample_value = '0;
   logic                req_first_of_sequence = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [OUT_W-1:0]    rsp_chain_length;
   logic [OUT_W-1:0]    rsp_greater_position;
   logic                rsp_overflow;

   value_item_type   pending_items[$];
   chain_result_type expected_chains[$];

   logic [OUT_W-1:0] latest_pos_tree [0:2*LEAVES-1];
   logic [OUT_W-1:0] chain_len_mem [0:CAPACITY-1];
   int               seq_items = 0;

   int   cycle_count = 0;
   logic rsp_hold = 1'b0;
   int   error_count = 0;

   previous_greater_chain_length #(
      .VALUE_BITS (VALUE_BITS_DEFAULT),
      .MAX_ITEMS  (MAX_ITEMS_DEFAULT)
   ) dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_sample_value      (req_sample_value),
      .req_first_of_sequence (req_first_of_sequence),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_chain_length      (rsp_chain_length),
      .rsp_greater_position  (rsp_greater_position),
      .rsp_overflow          (rsp_overflow)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      foreach (latest_pos_tree[i]) latest_pos_tree[i] = '0;
      foreach (chain_len_mem[i]) chain_len_mem[i] = '0;
   end

   function automatic chain_result_type predict_chain(logic [SAMPLE_W-1:0] sample,
                                                      logic first);
      chain_result_type res;
      int               lo;
      int               hi;
      int               node;
      logic [OUT_W-1:0] best;
      res = '0;
      if (first) begin
         foreach (latest_pos_tree[i]) latest_pos_tree[i] = '0;
         seq_items = 0;
      end
      if (seq_items >= CAPACITY) begin
         res.overflow = 1'b1;
         return res;
      end
      lo = int'(sample) + 1 + LEAVES;
      hi = 2 * LEAVES;
      best = '0;
      while (lo < hi) begin
         if (lo % 2 == 1) begin
            if (latest_pos_tree[lo] > best) best = latest_pos_tree[lo];
            lo++;
         end
         if (hi % 2 == 1) begin
            hi--;
            if (latest_pos_tree[hi] > best) best = latest_pos_tree[hi];
         end
         lo = lo >> 1;
         hi = hi >> 1;
      end
      res.greater_position = best;
      res.chain_length = (best != 0) ? OUT_W'(chain_len_mem[best - 1] + 1) : OUT_W'(1);
      seq_items++;
      chain_len_mem[seq_items - 1] = res.chain_length;
      node = int'(sample) + LEAVES;
      if (seq_items > latest_pos_tree[node]) latest_pos_tree[node] = OUT_W'(seq_items);
      node = node >> 1;
      while (node >= 1) begin
         latest_pos_tree[node] = (latest_pos_tree[2*node] > latest_pos_tree[2*node+1]) ?
                                 latest_pos_tree[2*node] : latest_pos_tree[2*node+1];
         node = node >> 1;
      end
      return res;
   endfunction

   task automatic add_item(int sample, bit first, bit drain);
      value_item_type item;
      item.sample = sample[SAMPLE_W-1:0];
      item.first = first;
      item.drain = drain;
      pending_items.push_back(item);
   endtask

   function automatic int next_sample(int style, int prev);
      int s;
      case (style)
         STYLE_FALLING: begin
            if ($urandom_range(0, 99) < 15 || prev < 9) s = $urandom_range(0, LEAVES - 1);
            else s = prev - $urandom_range(1, 8);
         end
         STYLE_CLUSTER: begin
            s = $urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(LEAVES - 8, LEAVES - 1);
         end
         STYLE_EXTREME: begin
            case ($urandom_range(0, 3))
               0: s = 0;
               1: s = LEAVES - 1;
               2: s = 1 << $urandom_range(0, SAMPLE_W - 1);
               default: s = $urandom_range(0, LEAVES - 1);
            endcase
         end
         default: s = $urandom_range(0, LEAVES - 1);
      endcase
      return s;
   endfunction

   task automatic add_short_sequences(int target);
      int len;
      int style;
      int prev;
      int pick;
      while (pending_items.size() < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) len = $urandom_range(1, 4);
         else if (pick < 85) len = $urandom_range(5, 20);
         else len = $urandom_range(21, 60);
         style = $urandom_range(STYLE_UNIFORM, STYLE_EXTREME);
         prev = $urandom_range(0, LEAVES - 1);
         for (int i = 0; i < len; i++) begin
            prev = next_sample(style, prev);
            add_item(prev, (i == 0) || ($urandom_range(0, 99) < 3), 1'b0);
         end
      end
   endtask

   task automatic flag_mismatch(string what, chain_result_type want, chain_result_type got);
      error_count++;
      if (error_count <= 10)
         $display("%0t %s: chain_length %0d/%0d greater_position %0d/%0d overflow %0b/%0b",
                  $time, what, want.chain_length, got.chain_length,
                  want.greater_position, got.greater_position, want.overflow, got.overflow);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      rsp_hold <= (cycle_count >= HOLD_START) && (cycle_count < HOLD_START + HOLD_LEN);
   end

   always @(posedge clock) begin
      logic holding;
      logic quiet;
      holding = 1'b0;
      quiet = (cycle_count >= QUIET_START) && (cycle_count < QUIET_END);
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_chains.push_back(predict_chain(req_sample_value, req_first_of_sequence));
            pending_items.delete(0);
         end else begin
            holding = req_valid;
         end
         if (!holding) begin
            if (pending_items.size() != 0 &&
                !(pending_items[0].drain && expected_chains.size() != 0) &&
                !(!quiet && $urandom_range(0, 99) < IDLE_PCT)) begin
               req_valid <= 1'b1;
               req_sample_value <= pending_items[0].sample;
               req_first_of_sequence <= pending_items[0].first;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      chain_result_type got;
      chain_result_type want;
      logic quiet;
      quiet = (cycle_count >= QUIET_START) && (cycle_count < QUIET_END);
      if (!reset && rsp_valid && !rsp_stall) begin
         got.chain_length = rsp_chain_length;
         got.greater_position = rsp_greater_position;
         got.overflow = rsp_overflow;
         if (expected_chains.size() == 0) begin
            flag_mismatch("unexpected result", '0, got);
         end else begin
            want = expected_chains.pop_front();
            if (got.chain_length !== want.chain_length ||
                got.greater_position !== want.greater_position ||
                got.overflow !== want.overflow)
               flag_mismatch("mismatch", want, got);
         end
      end
      rsp_stall <= rsp_hold || (!quiet && $urandom_range(0, 99) < IDLE_PCT);
   end

   initial begin
      int style;
      int prev;
      int base;

      // directed: no first flag after reset, top value, equal values, falling run
      add_item(5, 1'b0, 1'b0);
      add_item(LEAVES - 1, 1'b0, 1'b0);
      add_item(LEAVES - 1, 1'b0, 1'b0);
      add_item(0, 1'b0, 1'b0);
      add_item(512, 1'b0, 1'b0);
      add_item(300, 1'b0, 1'b0);
      add_item(300, 1'b0, 1'b0);
      add_item(0, 1'b0, 1'b0);
      add_item(LEAVES - 2, 1'b0, 1'b0);
      add_item(1, 1'b0, 1'b0);
      add_item(0, 1'b1, 1'b0);
      add_item(LEAVES - 1, 1'b0, 1'b0);
      add_item(1000, 1'b0, 1'b0);
      add_item(900, 1'b0, 1'b0);
      add_item(900, 1'b0, 1'b0);
      add_item(341, 1'b0, 1'b0);
      add_item(682, 1'b0, 1'b0);
      add_item(2, 1'b0, 1'b0);
      add_item(1, 1'b0, 1'b0);
      add_item(0, 1'b0, 1'b0);
      add_item(LEAVES - 1, 1'b1, 1'b0);
      add_item(LEAVES - 1, 1'b0, 1'b0);

      add_short_sequences(50);

      // fill to capacity after a full drain, then run past it
      prev = LEAVES - 1;
      style = STYLE_UNIFORM;
      for (int i = 0; i < CAPACITY + 5; i++) begin
         if (i % 64 == 0) style = $urandom_range(STYLE_UNIFORM, STYLE_EXTREME);
         prev = next_sample(style, prev);
         add_item(prev, i == 0, i == 0);
      end

      // single-item sequences, enough to wrap the epoch counter
      for (int i = 0; i < 252; i++) add_item($urandom_range(0, LEAVES - 1), 1'b1, i == 0);

      base = pending_items.size();
      add_short_sequences(base + 30);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (pending_items.size() != 0) @(posedge clock);
      while (expected_chains.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);

      if (error_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #2000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

[filelist.f]
rtl/core/pgcl_pkg.sv
rtl/core/previous_greater_chain_length.sv
tb/tb_previous_greater_chain_length.sv
